/* hw/rtl/dual_quadrature_speed_meter_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual quadrature speed meter
// Shared property wrappers clocked on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_SPEED_METER_UNIT_DEFINES_SVH
`define DUAL_QUADRATURE_SPEED_METER_UNIT_DEFINES_SVH

// Checked only while the block is out of reset.
`define DQSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define DQSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/dqsm_pkg.sv */
// ----------------------------------------------------------------------------
// Dual quadrature speed meter package
// Widths, command codes and sequencer states of the speed meter.
// ----------------------------------------------------------------------------
package dqsm_pkg;

  localparam int CNT_W     = 32;              // pulse counter width
  localparam int ELAPSED_W = 32;              // millisecond counter width
  localparam int SCALE_W   = 16;              // distance per pulse, Q0.16
  localparam int RATE_W    = 32;              // speed, signed Q16.16
  localparam int PROD_W    = CNT_W + SCALE_W; // product and quotient width
  localparam int LANES     = 2;               // left, right

  localparam int MUL_STEPS = SCALE_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 2 * RATE_W;
  localparam int OUT_USER_W = 1;

  typedef enum logic [IN_USER_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SPEED  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/dual_quadrature_speed_meter_unit.sv */
// ----------------------------------------------------------------------------
// Dual quadrature speed meter
// Two x4 quadrature decoders with a millisecond timebase and a bit-serial
// speed computation in signed Q16.16.
// ----------------------------------------------------------------------------
// A pin sample or a millisecond tick is taken in the idle state, so the
// block stays ready for the next word. A speed command with a nonzero
// elapsed time holds the input while it runs the shift-add multiplier (one
// bit of distance_per_pulse per cycle), the restoring divider (one quotient
// bit per cycle), saturation and the load of the output register, which
// waits for the sink to take its previous word. A speed command with zero
// elapsed time goes straight to the output load. Both channels are computed
// side by side.
// ----------------------------------------------------------------------------
`include "dual_quadrature_speed_meter_unit_defines.svh"

module dual_quadrature_speed_meter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] left_channel_a, [1] left_channel_b, [2] right_channel_a,
  // [3] right_channel_b, [7:4] zero
  input  logic [dqsm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] command
  input  logic [dqsm_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] left_speed, [63:32] right_speed
  output logic [dqsm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] updated
  output logic [dqsm_pkg::OUT_USER_W-1:0]  out_tuser,
  input  logic                             cfg_we,
  input  logic [dqsm_pkg::SCALE_W-1:0]     cfg_wdata
);
  import dqsm_pkg::*;

  localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;
  localparam logic [SCALE_W-1:0] DPP_RESET = SCALE_W'(4050);

  // Returns {down, up} for a move from phase p_old to phase p_now.
  function automatic logic [1:0] quad_dir(input logic [1:0] p_old,
                                          input logic [1:0] p_now);
    logic [1:0] dir;
    dir = 2'b00;
    unique case ({p_old, p_now})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = 2'b01;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = 2'b10;
      default:                            dir = 2'b00;
    endcase
    return dir;
  endfunction

  function automatic logic [RATE_W-1:0] saturate(input logic [PROD_W-1:0] q,
                                                 input logic neg);
    logic big;
    logic [RATE_W-1:0] res;
    big = |q[PROD_W-1:RATE_W-1];
    if (neg) begin
      res = big ? RATE_MIN : RATE_W'(0) - q[RATE_W-1:0];
    end else begin
      res = big ? RATE_MAX : q[RATE_W-1:0];
    end
    return res;
  endfunction

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [SCALE_W-1:0]    dpp_r, dpp_nxt;
  logic [SCALE_W-1:0]    dpp_sh_r, dpp_sh_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic                  upd_r, upd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_upd_r, out_upd_nxt;

  logic [1:0]            phase_r [LANES];
  logic [1:0]            phase_nxt [LANES];
  logic [CNT_W-1:0]      pulses_r [LANES];
  logic [CNT_W-1:0]      pulses_nxt [LANES];
  logic [CNT_W-1:0]      mag_r [LANES];
  logic [CNT_W-1:0]      mag_nxt [LANES];
  logic                  neg_r [LANES];
  logic                  neg_nxt [LANES];
  logic [PROD_W-1:0]     acc_r [LANES];
  logic [PROD_W-1:0]     acc_nxt [LANES];
  logic [ELAPSED_W-1:0]  rem_r [LANES];
  logic [ELAPSED_W-1:0]  rem_nxt [LANES];
  logic [RATE_W-1:0]     rate_r [LANES];
  logic [RATE_W-1:0]     rate_nxt [LANES];

  logic [ELAPSED_W:0]    rem_sh [LANES];
  logic                  fits [LANES];
  logic [1:0]            pin_now [LANES];
  logic [1:0]            dir [LANES];
  logic                  in_fire;
  cmd_t                  cmd;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cmd        = cmd_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;

  assign pin_now[0] = {in_tdata[1], in_tdata[0]};
  assign pin_now[1] = {in_tdata[3], in_tdata[2]};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    dpp_nxt       = cfg_we ? cfg_wdata : dpp_r;
    dpp_sh_nxt    = dpp_sh_r;
    elapsed_nxt   = elapsed_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_upd_nxt   = out_upd_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    for (int i = 0; i < LANES; i++) begin
      phase_nxt[i]  = phase_r[i];
      pulses_nxt[i] = pulses_r[i];
      mag_nxt[i]    = mag_r[i];
      neg_nxt[i]    = neg_r[i];
      acc_nxt[i]    = acc_r[i];
      rem_nxt[i]    = rem_r[i];
      rate_nxt[i]   = rate_r[i];
      dir[i]        = quad_dir(phase_r[i], pin_now[i]);
      // One restoring division step: shift in the next dividend bit.
      rem_sh[i]     = {rem_r[i], acc_r[i][PROD_W-1]};
      fits[i]       = rem_sh[i] >= {1'b0, elapsed_r};
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_SAMPLE: begin
              for (int i = 0; i < LANES; i++) begin
                phase_nxt[i] = pin_now[i];
                if (dir[i][0]) begin
                  pulses_nxt[i] = pulses_r[i] + 1'b1;
                end else if (dir[i][1]) begin
                  pulses_nxt[i] = pulses_r[i] - 1'b1;
                end
              end
            end
            CMD_TICK: begin
              if (elapsed_r != ELAPSED_TOP) begin
                elapsed_nxt = elapsed_r + 1'b1;
              end
            end
            CMD_SPEED: begin
              if (elapsed_r == '0) begin
                upd_nxt   = 1'b0;
                state_nxt = ST_OUT;
              end else begin
                for (int i = 0; i < LANES; i++) begin
                  neg_nxt[i] = pulses_r[i][CNT_W-1];
                  // The most negative count keeps its own bit pattern,
                  // which is the right magnitude when read unsigned.
                  mag_nxt[i] = pulses_r[i][CNT_W-1] ? CNT_W'(0) - pulses_r[i]
                                                    : pulses_r[i];
                  acc_nxt[i] = '0;
                  rem_nxt[i] = '0;
                end
                dpp_sh_nxt = dpp_r;
                step_nxt   = '0;
                state_nxt  = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        // Shift-add, most significant bit of the scale first.
        for (int i = 0; i < LANES; i++) begin
          acc_nxt[i] = {acc_r[i][PROD_W-2:0], 1'b0}
                       + (dpp_sh_r[SCALE_W-1] ? PROD_W'(mag_r[i]) : PROD_W'(0));
        end
        dpp_sh_nxt = {dpp_sh_r[SCALE_W-2:0], 1'b0};
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV: begin
        // The product shifts out at the top while quotient bits enter below.
        for (int i = 0; i < LANES; i++) begin
          rem_nxt[i] = fits[i] ? ELAPSED_W'(rem_sh[i] - {1'b0, elapsed_r})
                               : rem_sh[i][ELAPSED_W-1:0];
          acc_nxt[i] = {acc_r[i][PROD_W-2:0], fits[i]};
        end
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SAT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SAT: begin
        for (int i = 0; i < LANES; i++) begin
          rate_nxt[i]   = saturate(acc_r[i], neg_r[i]);
          pulses_nxt[i] = '0;
        end
        elapsed_nxt = '0;
        upd_nxt     = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rate_r[1], rate_r[0]};
          out_upd_nxt   = upd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      dpp_r       <= DPP_RESET;
      elapsed_r   <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        phase_r[i]  <= '0;
        pulses_r[i] <= '0;
        rate_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dpp_r       <= dpp_nxt;
      elapsed_r   <= elapsed_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < LANES; i++) begin
        phase_r[i]  <= phase_nxt[i];
        pulses_r[i] <= pulses_nxt[i];
        rate_r[i]   <= rate_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    dpp_sh_r   <= dpp_sh_nxt;
    out_data_r <= out_data_nxt;
    out_upd_r  <= out_upd_nxt;
    for (int i = 0; i < LANES; i++) begin
      mag_r[i] <= mag_nxt[i];
      neg_r[i] <= neg_nxt[i];
      acc_r[i] <= acc_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

  // A speed command with time on the clock must start the multiplier.
  `DQSM_ASSERT(a_speed_starts_mul, in_fire && cmd == CMD_SPEED && elapsed_r != '0 |=> state_r == ST_MUL, "speed command did not start the multiplier")
  // The divisor must stay nonzero for the whole computation.
  `DQSM_ASSERT(a_divisor_nonzero, state_r == ST_MUL || state_r == ST_DIV |-> elapsed_r != '0, "divisor is zero during a computation")
  // Saturation must restart the timebase and the counts.
  `DQSM_ASSERT(a_sat_clears, state_r == ST_SAT |=> elapsed_r == '0 && pulses_r[0] == '0 && pulses_r[1] == '0, "counters not cleared after a computation")
  // No word may be offered right after reset.
  `DQSM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

/* tb/sv/tb_dual_quadrature_speed_meter_unit.sv */
// ----------------------------------------------------------------------------
// Testbench of the dual quadrature speed meter
// Drives pin samples, millisecond ticks and speed commands into the block,
// predicts each speed report from its own model of both decoders and checks
// every report that comes out, with random idling on both streams outside the calm burst.
// ----------------------------------------------------------------------------
module tb_dual_quadrature_speed_meter_unit;
  import dqsm_pkg::*;

  localparam logic [IN_USER_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [SCALE_W-1:0] DEFAULT_SCALE = 16'd4050;
  localparam int SETTLE_CYCLES = 100;
  localparam int TIMEOUT_UNITS = 4_000_000;
  localparam int BURST_STEPS = 300;

  typedef struct packed {
    logic [IN_USER_W-1:0] command;
    logic [3:0]           pins;   // {right B, right A, left B, left A}
  } word_t;

  typedef struct {
    logic [RATE_W-1:0] left_speed;
    logic [RATE_W-1:0] right_speed;
    logic              updated;
  } speed_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [OUT_USER_W-1:0]  out_tuser;
  logic                   cfg_we = 1'b0;
  logic [SCALE_W-1:0]     cfg_wdata = '0;

  // No idling on either side while this is set.
  logic calm = 1'b0;

  word_t         pending_words[$];
  speed_report_t speed_reports[$];
  word_t         next_word;
  int            mismatches = 0;

  // Predicted state of the block.
  logic [SCALE_W-1:0]   meter_scale = DEFAULT_SCALE;
  logic [1:0]           left_phase = '0;
  logic [1:0]           right_phase = '0;
  logic [CNT_W-1:0]     left_pulses = '0;
  logic [CNT_W-1:0]     right_pulses = '0;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic [RATE_W-1:0]    left_rate = '0;
  logic [RATE_W-1:0]    right_rate = '0;

  // Pin phases that the stimulus generator has last sent.
  logic [1:0] gen_left = '0;
  logic [1:0] gen_right = '0;

  dual_quadrature_speed_meter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [CNT_W-1:0] count_step(logic [CNT_W-1:0] pulses,
                                                  logic [1:0] was, logic [1:0] now);
    case ({was, now})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: return pulses + 1'b1;
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: return pulses - 1'b1;
      default: return pulses;
    endcase
  endfunction

  // Truncated quotient, saturated to the signed 32-bit range.
  function automatic logic [RATE_W-1:0] speed_q16(logic [CNT_W-1:0] pulses,
                                                 logic [ELAPSED_W-1:0] ms,
                                                 logic [SCALE_W-1:0] scale);
    logic [63:0] mag;
    logic [63:0] quot;
    mag = pulses[CNT_W-1] ? {32'd0, -pulses} : {32'd0, pulses};
    quot = (mag * scale) / ms;
    if (pulses[CNT_W-1]) begin
      if (quot >= 64'h8000_0000) return 32'h8000_0000;
      return -quot[31:0];
    end
    if (quot > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return quot[31:0];
  endfunction

  task automatic predict_word(logic [IN_USER_W-1:0] command, logic [3:0] pins);
    speed_report_t report;
    case (command)
      CMD_SAMPLE: begin
        left_pulses = count_step(left_pulses, left_phase, pins[1:0]);
        right_pulses = count_step(right_pulses, right_phase, pins[3:2]);
        left_phase = pins[1:0];
        right_phase = pins[3:2];
      end
      CMD_TICK: begin
        if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
      end
      CMD_SPEED: begin
        report.updated = 1'b0;
        if (elapsed_ms != 0) begin
          left_rate = speed_q16(left_pulses, elapsed_ms, meter_scale);
          right_rate = speed_q16(right_pulses, elapsed_ms, meter_scale);
          left_pulses = '0;
          right_pulses = '0;
          elapsed_ms = '0;
          report.updated = 1'b1;
        end
        report.left_speed = left_rate;
        report.right_speed = right_rate;
        speed_reports.push_back(report);
      end
      default: ;
    endcase
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        next_word = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_word.command;
        in_tdata <= {4'd0, next_word.pins};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || $urandom_range(99) >= 9;
  end

  // Output checks come first so that a report is never compared with the
  // expectation of a word accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (speed_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected speed word, left %h right %h updated %b", $time,
                 out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
      end else begin
        speed_report_t want;
        want = speed_reports.pop_front();
        if (out_tdata[31:0] !== want.left_speed) begin
          mismatches++;
          $display("%0t: left_speed expected %h actual %h", $time,
                   want.left_speed, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.right_speed) begin
          mismatches++;
          $display("%0t: right_speed expected %h actual %h", $time,
                   want.right_speed, out_tdata[63:32]);
        end
        if (out_tuser[0] !== want.updated) begin
          mismatches++;
          $display("%0t: updated expected %b actual %b", $time,
                   want.updated, out_tuser[0]);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) predict_word(in_tuser, in_tdata[3:0]);
  end

  function automatic logic [1:0] next_phase(logic [1:0] p, int dir);
    if (dir == 1) begin
      case (p)
        2'd0: return 2'd1;
        2'd1: return 2'd3;
        2'd3: return 2'd2;
        default: return 2'd0;
      endcase
    end else if (dir == -1) begin
      case (p)
        2'd0: return 2'd2;
        2'd2: return 2'd3;
        2'd3: return 2'd1;
        default: return 2'd0;
      endcase
    end else if (dir == 2) begin
      return p ^ 2'b11;   // jump to the opposite phase
    end
    return p;
  endfunction

  task automatic push_word(logic [IN_USER_W-1:0] command, logic [3:0] pins);
    word_t w;
    w.command = command;
    w.pins = pins;
    pending_words.push_back(w);
  endtask

  task automatic push_motion(int left_dir, int right_dir);
    gen_left = next_phase(gen_left, left_dir);
    gen_right = next_phase(gen_right, right_dir);
    push_word(CMD_SAMPLE, {gen_right, gen_left});
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_word(CMD_TICK, 4'd0);
  endtask

  // Motion runs with random direction and length, sprinkled with noise,
  // each closed by zero to 60 ticks and one or two speed commands.
  task automatic push_random_traffic(int budget);
    int pushed;
    int seg_len;
    int left_dir;
    int right_dir;
    int roll;
    int ticks;
    logic [3:0] pins;
    pushed = 0;
    while (pushed < budget) begin
      left_dir = int'($urandom_range(2)) - 1;
      right_dir = int'($urandom_range(2)) - 1;
      seg_len = ($urandom_range(19) == 0) ? $urandom_range(300, 60) : $urandom_range(25, 1);
      for (int s = 0; s < seg_len; s++) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          pins = 4'($urandom_range(15));
          gen_left = pins[1:0];
          gen_right = pins[3:2];
          push_word(CMD_SAMPLE, pins);
        end else if (roll < 8) begin
          push_motion(2, ($urandom_range(1) == 0) ? 2 : right_dir);
        end else if (roll < 18) begin
          push_ticks(1);
        end else if (roll < 20) begin
          push_word(CMD_UNUSED, 4'($urandom_range(15)));
        end else begin
          push_motion(left_dir, right_dir);
        end
      end
      ticks = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(4);
      push_ticks(ticks);
      push_word(CMD_SPEED, 4'd0);
      pushed += seg_len + ticks + 1;
      if ($urandom_range(9) == 0) begin
        push_word(CMD_SPEED, 4'd0);
        pushed++;
      end
    end
  endtask

  // Waits until every word is in and every report out, then lets the block
  // finish whatever command carries no report.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || speed_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    meter_scale = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [SCALE_W-1:0] phase_scale[5];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Speed with no elapsed time, an unused command, one full turn forward on the
    // left and backward on the right, a phase jump on both and three steps back.
    push_word(CMD_SPEED, 4'd0);
    push_word(CMD_UNUSED, 4'hF);
    repeat (4) push_motion(1, -1);
    push_motion(2, 2);
    push_motion(0, 0);
    repeat (3) push_motion(-1, 1);
    push_ticks(3);
    push_word(CMD_SPEED, 4'd0);
    push_word(CMD_SPEED, 4'd0);
    push_ticks(1);
    push_word(CMD_SPEED, 4'd0);
    wait_drained();

    // A fast burst within one millisecond at the largest scale, with no
    // idling on either side.
    write_scale(16'hFFFF);
    calm <= 1'b1;
    repeat (BURST_STEPS) push_motion(1, -1);
    push_ticks(1);
    push_word(CMD_SPEED, 4'd0);
    push_ticks(1);
    push_word(CMD_SPEED, 4'd0);
    wait_drained();
    calm <= 1'b0;

    phase_scale[0] = 16'd0;
    phase_scale[1] = 16'hFFFF;
    phase_scale[2] = 16'($urandom);
    phase_scale[3] = 16'd1;
    phase_scale[4] = DEFAULT_SCALE;
    for (int p = 0; p < 5; p++) begin
      write_scale(phase_scale[p]);
      push_random_traffic(270);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* dual_quadrature_speed_meter_unit.f */
+incdir+hw/rtl
hw/rtl/dqsm_pkg.sv
hw/rtl/dual_quadrature_speed_meter_unit.sv
tb/sv/tb_dual_quadrature_speed_meter_unit.sv
